// ----- src/assert_macros.svh -----
// Assertion helpers; every use assumes clk_i and rst_ni are in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property, checked on every clock edge outside reset
`define WTS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Condition now implies another condition on the next edge
`define WTS_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

// ----- src/wts_pkg.sv -----
`default_nettype none
package wts_pkg;

  localparam int WINDOW_MAX = 64;
  localparam int DEPTH      = WINDOW_MAX + 1;
  localparam int AW         = $clog2(DEPTH);
  localparam int SAMPLE_W   = 24;
  localparam int CNT_W      = 7;
  localparam int OUT_W      = 24;
  localparam int PCT_W      = 16;
  localparam int RSUM_W     = 30;
  localparam int SQ_W       = 54;
  localparam int DSUM_W     = 31;
  localparam int NUM_W      = 64;
  localparam int DEN_W      = 26;
  localparam int DIV_CW     = 7;
  localparam int ROOT_W     = 32;
  localparam int PADDR_W    = 3;
  localparam int PDATA_W    = 32;

  localparam logic [CNT_W-1:0] WL_RESET = 7'd7;
  localparam logic             REG_WINDOW_LENGTH = 1'b0;

  // Start request for the shared divider
  typedef struct packed {
    logic              start;
    logic [DIV_CW-1:0] nbits;
  } div_req_t;

  // Status of a serial unit
  typedef struct packed {
    logic busy;
    logic done;
  } unit_stat_t;

endpackage
`default_nettype wire

// ----- src/wts_ram.sv -----
`default_nettype none
module wts_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

// ----- src/wts_div.sv -----
`default_nettype none
module wts_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  wts_pkg::div_req_t           req_i,
  input  logic [wts_pkg::NUM_W-1:0]   num_i,
  input  logic [wts_pkg::DEN_W-1:0]   den_i,
  output wts_pkg::unit_stat_t         stat_o,
  output logic [wts_pkg::NUM_W-1:0]   quot_o
);
  import wts_pkg::*;

  logic [NUM_W-1:0]  n_q, n_d, quot_q, quot_d;
  logic [DEN_W-1:0]  den_q, den_d, rem_q, rem_d;
  logic [DIV_CW-1:0] cnt_q, cnt_d;
  logic              busy_q, busy_d, done_q, done_d;
  logic [DEN_W:0]    trial, diff;
  logic              ge;

  // One quotient bit per cycle, numerator enters MSB first
  always_comb begin
    trial  = {rem_q, n_q[NUM_W-1]};
    ge     = trial >= {1'b0, den_q};
    diff   = trial - {1'b0, den_q};
    n_d    = n_q;
    quot_d = quot_q;
    den_d  = den_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (req_i.start) begin
      n_d    = num_i;
      den_d  = den_i;
      rem_d  = '0;
      quot_d = '0;
      cnt_d  = req_i.nbits;
      busy_d = 1'b1;
    end else if (busy_q) begin
      n_d    = {n_q[NUM_W-2:0], 1'b0};
      quot_d = {quot_q[NUM_W-2:0], ge};
      rem_d  = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      cnt_d  = cnt_q - 1'b1;
      if (cnt_q == DIV_CW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q    <= n_d;
    quot_q <= quot_d;
    den_q  <= den_d;
    rem_q  <= rem_d;
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign quot_o      = quot_q;

endmodule
`default_nettype wire

// ----- src/wts_sqrt.sv -----
`default_nettype none
module wts_sqrt (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [wts_pkg::NUM_W-1:0]   val_i,
  output wts_pkg::unit_stat_t         stat_o,
  output logic [wts_pkg::ROOT_W-1:0]  root_o
);
  import wts_pkg::*;

  localparam int REM_W = ROOT_W + 2;
  localparam int CW    = $clog2(ROOT_W + 1);

  logic [NUM_W-1:0]  v_q, v_d;
  logic [REM_W-1:0]  rem_q, rem_d;
  logic [ROOT_W-1:0] root_q, root_d;
  logic [CW-1:0]     cnt_q, cnt_d;
  logic              busy_q, busy_d, done_q, done_d;
  logic [REM_W+1:0]  cur, trial, diff;
  logic              ge;

  // Two radicand bits and one root bit per cycle
  always_comb begin
    cur    = {rem_q, v_q[NUM_W-1 -: 2]};
    trial  = {2'b00, root_q, 2'b01};
    ge     = cur >= trial;
    diff   = cur - trial;
    v_d    = v_q;
    rem_d  = rem_q;
    root_d = root_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      v_d    = val_i;
      rem_d  = '0;
      root_d = '0;
      cnt_d  = CW'(ROOT_W);
      busy_d = 1'b1;
    end else if (busy_q) begin
      v_d    = {v_q[NUM_W-3:0], 2'b00};
      rem_d  = ge ? diff[REM_W-1:0] : cur[REM_W-1:0];
      root_d = {root_q[ROOT_W-2:0], ge};
      cnt_d  = cnt_q - 1'b1;
      if (cnt_q == CW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    v_q    <= v_d;
    rem_q  <= rem_d;
    root_q <= root_d;
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign root_o      = root_q;

endmodule
`default_nettype wire

// ----- src/window_trend_statistics_top.sv -----
// Flow per item: scan the window newest first, set up operands, then bit-serial mean,
// percent and variance division on the shared divider, square root, then output load.
// A zero oldest sample skips the percent; with exactly P held (P = period) the mean and
// percent are skipped; with fewer, all division and the root. One item at a time.
// Reset: asynchronous, active low; clears fill level, previous percent, switch
// count and control state, and sets window_length to 7. Window RAM is not cleared.
`default_nettype none
`include "assert_macros.svh"
module window_trend_statistics_top (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [wts_pkg::PADDR_W-1:0]         paddr,
  input  logic [wts_pkg::PDATA_W-1:0]         pwdata,
  output logic [wts_pkg::PDATA_W-1:0]         prdata,
  output logic                                pready,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic signed [wts_pkg::SAMPLE_W-1:0] sample_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic                                rise_valid_o,
  output logic [wts_pkg::OUT_W-1:0]           mean_rise_o,
  output logic signed [wts_pkg::PCT_W-1:0]    percent_change_o,
  output logic                                percent_fault_o,
  output logic                                spread_valid_o,
  output logic [wts_pkg::OUT_W-1:0]           std_deviation_o,
  output logic                                switch_seen_o,
  output logic [wts_pkg::PCT_W-1:0]           switch_total_o
);
  import wts_pkg::*;

  localparam logic [3:0] ST_IDLE   = 4'd0;
  localparam logic [3:0] ST_SCAN   = 4'd1;
  localparam logic [3:0] ST_PREP   = 4'd2;
  localparam logic [3:0] ST_MEAN_S = 4'd3;
  localparam logic [3:0] ST_MEAN_W = 4'd4;
  localparam logic [3:0] ST_PCT_S  = 4'd5;
  localparam logic [3:0] ST_PCT_W  = 4'd6;
  localparam logic [3:0] ST_VAR_M  = 4'd7;
  localparam logic [3:0] ST_VAR_S  = 4'd8;
  localparam logic [3:0] ST_VAR_W  = 4'd9;
  localparam logic [3:0] ST_SQ_W   = 4'd10;
  localparam logic [3:0] ST_DONE   = 4'd11;

  localparam int PNUM_W = 33;
  localparam int PDEN_W = 25;
  localparam int VNUM_W = 61;

  // Control registers
  logic [3:0]       state_q, state_d;
  logic [CNT_W-1:0] wl_q, fill_q, fill_new, p_q, p_new, nread_q, kiss_q, kd_q;
  logic [AW-1:0]    wp_q, rd_addr_q;
  logic             dv_q, rv_q, sv_q, rv_new, sv_new;
  logic             out_vld_q;
  logic signed [PCT_W-1:0] prev_q;
  logic [PCT_W-1:0] cnt_q;
  logic             accept, load_out;

  // Datapath registers
  logic signed [SAMPLE_W-1:0] x_q, base_q, newer_q, oldest_q;
  logic [RSUM_W-1:0]          rsum_q;
  logic [SQ_W-1:0]            sq_q;
  logic signed [DSUM_W-1:0]   dsum_q;
  logic [PNUM_W-1:0]          pnum_q;
  logic [PDEN_W-1:0]          pden_q;
  logic                       pneg_q;
  logic [VNUM_W-1:0]          sqp_q;
  logic [2*DSUM_W-1:0]        ds2_q;
  logic [OUT_W-1:0]           mean_q, sd_q;
  logic signed [PCT_W-1:0]    pct_q;
  logic                       pf_q;

  // Output registers
  logic                       o_rv_q, o_pf_q, o_sv_q, o_seen_q;
  logic [OUT_W-1:0]           o_mean_q, o_sd_q;
  logic signed [PCT_W-1:0]    o_pct_q;

  // Unit connections
  logic signed [SAMPLE_W-1:0] rdata;
  logic [SAMPLE_W-1:0]        rdata_raw;
  div_req_t                   div_req;
  logic [NUM_W-1:0]           div_num, div_quot;
  logic [DEN_W-1:0]           div_den;
  unit_stat_t                 div_st, sq_st;
  logic [ROOT_W-1:0]          root;
  logic                       sq_start;

  // Configuration port
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_WINDOW_LENGTH) ? PDATA_W'(wl_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wl_q <= WL_RESET;
    end else if (psel && penable && pwrite && pready && paddr[2] == REG_WINDOW_LENGTH) begin
      wl_q <= pwdata[CNT_W-1:0];
    end
  end

  // Item intake: clamp the period, bump fill, decide validity
  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    if (wl_q == '0) begin
      p_new = CNT_W'(1);
    end else if (wl_q > CNT_W'(WINDOW_MAX)) begin
      p_new = CNT_W'(WINDOW_MAX);
    end else begin
      p_new = wl_q;
    end
    fill_new = (fill_q == CNT_W'(DEPTH)) ? fill_q : fill_q + 1'b1;
    rv_new   = fill_new >= p_new + 1'b1;
    sv_new   = fill_new >= p_new;
  end

  wts_ram #(.Width(SAMPLE_W), .Depth(DEPTH)) u_window (
    .clk_i   (clk_i),
    .we_i    (accept),
    .waddr_i (wp_q),
    .wdata_i (sample_i),
    .raddr_i (rd_addr_q),
    .rdata_o (rdata_raw)
  );
  assign rdata = rdata_raw;

  // Scan datapath, one window entry per cycle, newest first
  logic signed [SAMPLE_W-1:0] base_cur;
  logic signed [SAMPLE_W:0]   dd, rdiff;
  logic [SAMPLE_W-1:0]        ddm;
  logic [2*SAMPLE_W-1:0]      ddsq;
  assign base_cur = (kd_q == '0) ? rdata : base_q;
  assign dd       = {rdata[SAMPLE_W-1], rdata} - {base_cur[SAMPLE_W-1], base_cur};
  assign ddm      = dd[SAMPLE_W] ? SAMPLE_W'(-dd) : dd[SAMPLE_W-1:0];
  assign ddsq     = ddm * ddm;
  assign rdiff    = {newer_q[SAMPLE_W-1], newer_q} - {rdata[SAMPLE_W-1], rdata};

  // Percent operands
  logic signed [SAMPLE_W:0] pdiff;
  logic [SAMPLE_W-1:0]      pdm, odm;
  logic [PNUM_W-2:0]        um;
  assign pdiff = {x_q[SAMPLE_W-1], x_q} - {oldest_q[SAMPLE_W-1], oldest_q};
  assign pdm   = pdiff[SAMPLE_W] ? SAMPLE_W'(-pdiff) : pdiff[SAMPLE_W-1:0];
  assign odm   = oldest_q[SAMPLE_W-1] ? SAMPLE_W'(-oldest_q) : oldest_q;
  assign um    = (PNUM_W-1)'(pdm) * (PNUM_W-1)'(100);

  // Variance operands
  logic [DSUM_W-1:0]  dsm;
  logic [VNUM_W-1:0]  vnum;
  logic [13:0]        pp;
  assign dsm  = dsum_q[DSUM_W-1] ? DSUM_W'(-dsum_q) : DSUM_W'(dsum_q);
  assign vnum = sqp_q - ds2_q[VNUM_W-1:0];
  assign pp   = 14'(p_q) * 14'(p_q);

  // Divider requests by state
  always_comb begin
    div_req.start = 1'b0;
    div_req.nbits = DIV_CW'(RSUM_W);
    div_num       = {rsum_q, {(NUM_W-RSUM_W){1'b0}}};
    div_den       = DEN_W'(p_q);
    case (state_q)
      ST_MEAN_S: div_req.start = 1'b1;
      ST_PCT_S: begin
        div_req.start = 1'b1;
        div_req.nbits = DIV_CW'(PNUM_W);
        div_num       = {pnum_q, {(NUM_W-PNUM_W){1'b0}}};
        div_den       = DEN_W'(pden_q);
      end
      ST_VAR_S: begin
        div_req.start = 1'b1;
        div_req.nbits = DIV_CW'(VNUM_W);
        div_num       = {vnum, {(NUM_W-VNUM_W){1'b0}}};
        div_den       = DEN_W'(pp);
      end
      default: ;
    endcase
  end

  wts_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .num_i  (div_num),
    .den_i  (div_den),
    .stat_o (div_st),
    .quot_o (div_quot)
  );

  assign sq_start = (state_q == ST_VAR_W) && div_st.done;

  wts_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sq_start),
    .val_i   (div_quot),
    .stat_o  (sq_st),
    .root_o  (root)
  );

  // Sequencer
  assign load_out = (state_q == ST_DONE) && (!out_vld_q || out_ready_i);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:   if (accept) state_d = ST_SCAN;
      ST_SCAN:   if (kiss_q == nread_q && !dv_q) state_d = ST_PREP;
      ST_PREP:   state_d = rv_q ? ST_MEAN_S : ST_VAR_M;
      ST_MEAN_S: state_d = ST_MEAN_W;
      ST_MEAN_W: if (div_st.done) state_d = (oldest_q != '0) ? ST_PCT_S : ST_VAR_M;
      ST_PCT_S:  state_d = ST_PCT_W;
      ST_PCT_W:  if (div_st.done) state_d = ST_VAR_M;
      ST_VAR_M:  state_d = sv_q ? ST_VAR_S : ST_DONE;
      ST_VAR_S:  state_d = ST_VAR_W;
      ST_VAR_W:  if (div_st.done) state_d = ST_SQ_W;
      ST_SQ_W:   if (sq_st.done) state_d = ST_DONE;
      ST_DONE:   if (load_out) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  // Switch detection on the finished percent
  logic flip;
  assign flip = (pct_q != '0) &&
                ((prev_q < 0 && pct_q > 0) || (prev_q > 0 && pct_q < 0));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      fill_q    <= '0;
      wp_q      <= '0;
      rd_addr_q <= '0;
      kiss_q    <= '0;
      kd_q      <= '0;
      nread_q   <= '0;
      p_q       <= CNT_W'(1);
      dv_q      <= 1'b0;
      rv_q      <= 1'b0;
      sv_q      <= 1'b0;
      out_vld_q <= 1'b0;
      prev_q    <= '0;
      cnt_q     <= '0;
    end else begin
      state_q <= state_d;
      dv_q    <= 1'b0;
      if (accept) begin
        fill_q    <= fill_new;
        wp_q      <= (wp_q == AW'(DEPTH-1)) ? '0 : wp_q + 1'b1;
        rd_addr_q <= wp_q;
        kiss_q    <= '0;
        p_q       <= p_new;
        rv_q      <= rv_new;
        sv_q      <= sv_new;
        nread_q   <= rv_new ? p_new + 1'b1 : fill_new;
      end
      // issue one read a cycle
      if (state_q == ST_SCAN && kiss_q != nread_q) begin
        rd_addr_q <= (rd_addr_q == '0) ? AW'(DEPTH-1) : rd_addr_q - 1'b1;
        kiss_q    <= kiss_q + 1'b1;
        kd_q      <= kiss_q;
        dv_q      <= 1'b1;
      end
      if (load_out) begin
        out_vld_q <= 1'b1;
        prev_q    <= pct_q;
        if (flip && cnt_q != '1) begin
          cnt_q <= cnt_q + 1'b1;
        end
      end else if (out_ready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // Datapath updates
  always_ff @(posedge clk_i) begin
    if (accept) begin
      x_q    <= sample_i;
      rsum_q <= '0;
      sq_q   <= '0;
      dsum_q <= '0;
      mean_q <= '0;
      pct_q  <= '0;
      pf_q   <= 1'b0;
      sd_q   <= '0;
    end
    // accumulate the entry that came back from the RAM
    if (dv_q) begin
      newer_q <= rdata;
      if (kd_q == '0) begin
        base_q <= rdata;
      end else if (!rdiff[SAMPLE_W] && rdiff != '0) begin
        rsum_q <= rsum_q + RSUM_W'(rdiff[SAMPLE_W-1:0]);
      end
      if (kd_q < p_q) begin
        sq_q   <= sq_q + SQ_W'(ddsq);
        dsum_q <= dsum_q + DSUM_W'(dd);
      end
      if (kd_q == p_q) begin
        oldest_q <= rdata;
      end
    end
    if (state_q == ST_PREP) begin
      pnum_q <= {um, 1'b0} + PNUM_W'(odm);
      pden_q <= {odm, 1'b0};
      pneg_q <= pdiff[SAMPLE_W] != oldest_q[SAMPLE_W-1];
    end
    if (state_q == ST_MEAN_W && div_st.done) begin
      mean_q <= (div_quot[NUM_W-1:OUT_W] != '0) ? '1 : div_quot[OUT_W-1:0];
      pf_q   <= (oldest_q == '0);
    end
    // round half away from zero, then saturate
    if (state_q == ST_PCT_W && div_st.done) begin
      if (pneg_q) begin
        pct_q <= (div_quot[PNUM_W-1:0] > PNUM_W'(32768)) ? 16'sh8000
                                                          : PCT_W'(-div_quot[PCT_W-1:0]);
      end else begin
        pct_q <= (div_quot[PNUM_W-1:0] > PNUM_W'(32767)) ? 16'sh7FFF
                                                          : div_quot[PCT_W-1:0];
      end
    end
    if (state_q == ST_VAR_M) begin
      sqp_q <= VNUM_W'(sq_q) * VNUM_W'(p_q);
      ds2_q <= dsm * dsm;
    end
    if (state_q == ST_SQ_W && sq_st.done) begin
      sd_q <= (root[ROOT_W-1:OUT_W] != '0) ? '1 : root[OUT_W-1:0];
    end
    if (load_out) begin
      o_rv_q   <= rv_q;
      o_mean_q <= mean_q;
      o_pct_q  <= pct_q;
      o_pf_q   <= pf_q;
      o_sv_q   <= sv_q;
      o_sd_q   <= sd_q;
      o_seen_q <= flip;
    end
  end

  assign out_valid_o      = out_vld_q;
  assign rise_valid_o     = o_rv_q;
  assign mean_rise_o      = o_mean_q;
  assign percent_change_o = o_pct_q;
  assign percent_fault_o  = o_pf_q;
  assign spread_valid_o   = o_sv_q;
  assign std_deviation_o  = o_sd_q;
  assign switch_seen_o    = o_seen_q;
  assign switch_total_o   = cnt_q;

  // Checks
  `WTS_ASSERT(a_fill_bound, fill_q <= CNT_W'(DEPTH), "fill level beyond window depth")
  `WTS_ASSERT_NEXT(a_accept_busy, accept, state_q == ST_SCAN, "accepted item did not start scan")
  `WTS_ASSERT_NEXT(a_count_mono, 1'b1, cnt_q >= $past(cnt_q), "switch count decreased")
  `WTS_ASSERT_NEXT(a_done_loads, load_out, out_vld_q && state_q == ST_IDLE,
                   "finished result not presented")

endmodule
`default_nettype wire
